/* design/bmt_pkg.sv */
`timescale 1ns / 1ps

package bmt_pkg;

    localparam int MAX_ROWS_DEF = 256;
    localparam int MAX_COLS_DEF = 256;

    localparam logic [8:0] SIZE_RST = 9'd8;

    // register select, taken from paddr[2]
    localparam logic REG_ROW_COUNT = 1'b0;
    localparam logic REG_COL_COUNT = 1'b1;

    typedef enum logic {
        PH_LOAD,
        PH_EMIT
    } phase_t;

endpackage

/* design/bit_matrix_transpose.sv */
`timescale 1ns / 1ps

// Bit matrix transposer. Load words (req_type 0) bring the matrix in one byte at a
// time in row-major order; once row_count*col_count/8 bytes are in, fetch words
// (req_type 1) return the transpose one byte per fetch, column by column, with
// last_byte on the final one, after which the block loads again. A fetch during
// loading returns zero with not_ready set; a load during emitting is dropped. The
// matrix sits in eight row banks, one per row modulo eight, so one registered read
// of all eight banks yields a whole output byte. Busy stays low and a word may
// be offered in every cycle. A fetch result appears on out_byte, last_byte and
// not_ready with out_valid high for exactly one cycle, in the cycle after the
// fetch is accepted (the banks' registered read port); the receiver must take it
// then. Writing either size register restarts loading.

module bit_matrix_transpose #(
    parameter int MAX_ROWS = bmt_pkg::MAX_ROWS_DEF,
    parameter int MAX_COLS = bmt_pkg::MAX_COLS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        req_type,
    input  logic [7:0]  in_byte,
    output logic        out_valid,
    output logic [7:0]  out_byte,
    output logic        last_byte,
    output logic        not_ready,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int RG_MAX = MAX_ROWS / 8;
    localparam int CG_MAX = MAX_COLS / 8;
    localparam int RGI_W  = (RG_MAX > 1) ? $clog2(RG_MAX) : 1;
    localparam int CGI_W  = (CG_MAX > 1) ? $clog2(CG_MAX) : 1;
    localparam int DEPTH  = RG_MAX * CG_MAX;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    // clamp a size to [1, top] groups of eight and return the last group index
    function automatic int groups_last(logic [5:0] g, int top);
        int v;
        v = int'(g);
        if (v == 0)
        begin
            v = 1;
        end
        if (v > top)
        begin
            v = top;
        end
        return v - 1;
    endfunction

    logic [8:0] row_count_reg;
    logic [8:0] col_count_reg;

    bmt_pkg::phase_t phase_reg, phase_next;

    logic [RGI_W-1:0] lrgrp_reg, lrgrp_next;
    logic [2:0]       lrow_reg, lrow_next;
    logic [CGI_W-1:0] lcgrp_reg, lcgrp_next;
    logic [RGI_W-1:0] egrp_reg, egrp_next;
    logic [CGI_W-1:0] ecgrp_reg, ecgrp_next;
    logic [2:0]       ebit_reg, ebit_next;

    logic       out_valid_reg;
    logic       last_reg;
    logic       not_ready_reg;
    logic [2:0] shift_reg;

    logic [RGI_W-1:0]  rg_last;
    logic [CGI_W-1:0]  cg_last;
    logic              cfg_wr;
    logic              load_acc;
    logic              fetch_acc;
    logic              load_done;
    logic              emit_last;
    logic [ADDR_W-1:0] waddr;
    logic [ADDR_W-1:0] raddr;
    logic              rd_en;
    logic [7:0]        bank_we;
    logic [7:0]        bank_rd [8];
    logic [7:0]        gather;

    assign busy      = 1'b0;
    assign pready    = 1'b1;
    assign cfg_wr    = psel && penable && pwrite && pready;
    assign load_acc  = start && !busy && !req_type;
    assign fetch_acc = start && !busy && req_type;

    assign rg_last = RGI_W'(groups_last(row_count_reg[8:3], RG_MAX));
    assign cg_last = CGI_W'(groups_last(col_count_reg[8:3], CG_MAX));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_count_reg <= bmt_pkg::SIZE_RST;
            col_count_reg <= bmt_pkg::SIZE_RST;
        end
        else if (cfg_wr)
        begin
            if (paddr[2] == bmt_pkg::REG_ROW_COUNT)
            begin
                row_count_reg <= pwdata[8:0];
            end
            else
            begin
                col_count_reg <= pwdata[8:0];
            end
        end
    end

    assign prdata = (paddr[2] == bmt_pkg::REG_COL_COUNT) ? {23'd0, col_count_reg}
                                                         : {23'd0, row_count_reg};

    assign load_done = (lcgrp_reg == cg_last) && (lrow_reg == 3'd7) && (lrgrp_reg == rg_last);
    assign emit_last = (egrp_reg == rg_last) && (ebit_reg == 3'd7) && (ecgrp_reg == cg_last);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= bmt_pkg::PH_LOAD;
            lrgrp_reg <= '0;
            lrow_reg  <= '0;
            lcgrp_reg <= '0;
            egrp_reg  <= '0;
            ecgrp_reg <= '0;
            ebit_reg  <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            lrgrp_reg <= lrgrp_next;
            lrow_reg  <= lrow_next;
            lcgrp_reg <= lcgrp_next;
            egrp_reg  <= egrp_next;
            ecgrp_reg <= ecgrp_next;
            ebit_reg  <= ebit_next;
        end
    end

    always_comb
    begin
        phase_next = phase_reg;
        lrgrp_next = lrgrp_reg;
        lrow_next  = lrow_reg;
        lcgrp_next = lcgrp_reg;
        egrp_next  = egrp_reg;
        ecgrp_next = ecgrp_reg;
        ebit_next  = ebit_reg;
        if (cfg_wr)
        begin
            phase_next = bmt_pkg::PH_LOAD;
            lrgrp_next = '0;
            lrow_next  = '0;
            lcgrp_next = '0;
            egrp_next  = '0;
            ecgrp_next = '0;
            ebit_next  = '0;
        end
        else
        begin
            case (phase_reg)
                bmt_pkg::PH_LOAD:
                begin
                    if (load_acc)
                    begin
                        if (load_done)
                        begin
                            phase_next = bmt_pkg::PH_EMIT;
                            lrgrp_next = '0;
                            lrow_next  = '0;
                            lcgrp_next = '0;
                        end
                        else if (lcgrp_reg != cg_last)
                        begin
                            lcgrp_next = lcgrp_reg + 1'b1;
                        end
                        else
                        begin
                            lcgrp_next = '0;
                            lrow_next  = lrow_reg + 3'd1;
                            if (lrow_reg == 3'd7)
                            begin
                                lrgrp_next = lrgrp_reg + 1'b1;
                            end
                        end
                    end
                end
                bmt_pkg::PH_EMIT:
                begin
                    if (fetch_acc)
                    begin
                        if (emit_last)
                        begin
                            phase_next = bmt_pkg::PH_LOAD;
                            egrp_next  = '0;
                            ecgrp_next = '0;
                            ebit_next  = '0;
                        end
                        else if (egrp_reg != rg_last)
                        begin
                            egrp_next = egrp_reg + 1'b1;
                        end
                        else
                        begin
                            egrp_next = '0;
                            ebit_next = ebit_reg + 3'd1;
                            if (ebit_reg == 3'd7)
                            begin
                                ecgrp_next = ecgrp_reg + 1'b1;
                            end
                        end
                    end
                end
                default:
                begin
                    phase_next = bmt_pkg::PH_LOAD;
                end
            endcase
        end
    end

    // bank address: row group major, column group minor
    assign waddr = ADDR_W'(32'(lrgrp_reg) * CG_MAX + 32'(lcgrp_reg));
    assign raddr = ADDR_W'(32'(egrp_reg) * CG_MAX + 32'(ecgrp_reg));
    assign rd_en = fetch_acc && (phase_reg == bmt_pkg::PH_EMIT);

    always_comb
    begin
        for (int k = 0; k < 8; k++)
        begin
            bank_we[k] = load_acc && !cfg_wr && (phase_reg == bmt_pkg::PH_LOAD)
                         && (lrow_reg == 3'(k));
        end
    end

    for (genvar k = 0; k < 8; k++)
    begin : g_bank
        bmt_bank #(
            .DEPTH (DEPTH),
            .ADDR_W(ADDR_W)
        ) u_bank (
            .clk  (clk),
            .we   (bank_we[k]),
            .waddr(waddr),
            .wdata(in_byte),
            .re   (rd_en),
            .raddr(raddr),
            .rdata(bank_rd[k])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= fetch_acc;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fetch_acc)
        begin
            not_ready_reg <= (phase_reg == bmt_pkg::PH_LOAD);
            last_reg      <= (phase_reg == bmt_pkg::PH_EMIT) && emit_last;
            shift_reg     <= ebit_reg;
        end
    end

    // pick the addressed column bit out of each row bank
    always_comb
    begin
        for (int k = 0; k < 8; k++)
        begin
            gather[k] = bank_rd[k][shift_reg];
        end
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = not_ready_reg ? 8'h00 : gather;
    assign last_byte = last_reg;
    assign not_ready = not_ready_reg;

`ifndef ASSERT_OFF
    a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(not_ready && last_byte))
        else $error("last_byte and not_ready both set");

    a_fetch_emit: assert property (@(posedge clk) disable iff (!rst_n)
        fetch_acc && (phase_reg == bmt_pkg::PH_EMIT) |=> out_valid && !not_ready)
        else $error("fetch in emit phase gave no normal result");

    a_drop_load: assert property (@(posedge clk) disable iff (!rst_n)
        load_acc && !cfg_wr && (phase_reg == bmt_pkg::PH_EMIT)
        |=> $stable(egrp_reg) && $stable(ebit_reg) && $stable(ecgrp_reg)
            && (phase_reg == bmt_pkg::PH_EMIT))
        else $error("load during emit changed state");

    a_last_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        fetch_acc && !cfg_wr && (phase_reg == bmt_pkg::PH_EMIT) && emit_last
        |=> (phase_reg == bmt_pkg::PH_LOAD) && last_byte && (lrgrp_reg == '0)
            && (lrow_reg == 3'd0) && (lcgrp_reg == '0))
        else $error("last fetch did not return to loading");
`endif

endmodule

/* design/bmt_bank.sv */
`timescale 1ns / 1ps

module bmt_bank #(
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [7:0]        wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [7:0]        rdata
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // hold the last read word until the next read
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
